// ===== design/hse_pkg.sv =====
package hse_pkg;

  localparam int unsigned ByteBits  = 8;
  localparam int unsigned DataBits  = 26;
  localparam int unsigned CodeBits  = 31;
  localparam int unsigned ParBits   = 5;
  // pending store never holds more than DataBits-1 bits between items
  localparam int unsigned PendBits  = DataBits - 1;
  localparam int unsigned CountBits = 5;
  localparam int unsigned RestBits  = 3;
  localparam int unsigned WordBits  = 3;

  localparam logic [WordBits-1:0] LastWord = 3'd7;

  // one data word handed from the gearbox to the encoder
  typedef struct packed {
    logic                last;
    logic [DataBits-1:0] data;
  } hse_word_t;

endpackage

// ===== design/hamming_31_26_byte_stream_encoder.sv =====
// Hamming(31,26) encoder fed by a byte stream.
//
// Input channel s_axis_*: one message byte per item, bits consumed MSB first
// into a small pending store (gearbox). Each time 26 data bits have built up,
// one codeword leaves on m_axis_*; every 26 bytes give exactly eight words.
// Output channel m_axis_*: tdata[30:0] is the codeword (position 1 in bit 30,
// position 31 in bit 0), tdata[31] is zero; tlast marks the eighth word of a
// 26-byte section. Bits of a trailing partial word never come out.
//
// Throughput: one byte per cycle, sustained while m_axis_tready stays high;
// set by the gearbox update (shift, mask and count add) feeding a registered
// word stage. A codeword passes the gearbox word register, then the parity
// trees into the output register.
//
// Reset (rst, synchronous): pending store, bit count and section counter go
// to zero and both stages empty. Stall: while m_axis_tready is low the output
// register holds; the word stage still fills, and s_axis_tready drops only
// once both stages hold an item. Bytes that make no word keep flowing when
// the word stage can advance.
module hamming_31_26_byte_stream_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] codeword, [31] zero fill
  output logic        m_axis_tlast    // section_end
);
  import hse_pkg::*;

  hse_word_t   word;
  logic        word_valid;
  logic        word_ready;
  logic [30:0] codeword;

  hse_gearbox u_gearbox (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word)
  );

  hse_encoder u_encoder (
    .clk         (clk),
    .rst         (rst),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .word        (word),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .codeword    (codeword),
    .section_end (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, codeword};

endmodule

// ===== design/hse_gearbox.sv =====
module hse_gearbox (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  output logic               word_valid,
  input  logic               word_ready,
  output hse_pkg::hse_word_t word
);
  import hse_pkg::*;

  logic [PendBits-1:0]        pending, pending_next;
  logic [CountBits-1:0]       count, count_next;
  logic [WordBits-1:0]        wcnt;
  logic [CountBits:0]         sum;
  logic [CountBits:0]         rest_wide;
  logic [RestBits-1:0]        rest;
  logic [PendBits+ByteBits-1:0] cat, shifted, keep_mask;
  logic                       emit;
  logic                       accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !word_valid || word_ready;

  always_comb begin
    sum       = {1'b0, count} + 6'd8;
    emit      = (sum >= 6'd26);
    rest_wide = sum - 6'd26;
    rest      = rest_wide[RestBits-1:0];
    cat       = {pending, in_byte};
    // oldest bits sit high; drop the leftover low bits to get the word
    shifted   = cat >> rest;
    keep_mask = ({{(PendBits+ByteBits-1){1'b0}}, 1'b1} << rest) - 1'b1;
    if (emit) begin
      pending_next = cat[PendBits-1:0] & keep_mask[PendBits-1:0];
      count_next   = {{(CountBits-RestBits){1'b0}}, rest};
    end else begin
      pending_next = cat[PendBits-1:0];
      count_next   = sum[CountBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      count      <= '0;
      wcnt       <= '0;
      word_valid <= 1'b0;
    end else begin
      if (accept) begin
        pending <= pending_next;
        count   <= count_next;
        if (emit) begin
          wcnt <= wcnt + 3'd1;
        end
      end
      if (in_ready) begin
        word_valid <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      word.data <= shifted[DataBits-1:0];
      word.last <= (wcnt == LastWord);
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 5'd25) else $error("pending count out of range");

  a_clean_store: assert property (@(posedge clk) disable iff (rst)
    (pending >> count) == '0) else $error("stale bits above pending count");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && count < 5'd18) |=> (count == $past(count) + 5'd8))
    else $error("pending count did not grow by one byte");

  a_section_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && emit && wcnt == LastWord) |=> (wcnt == '0 && word_valid && word.last))
    else $error("section end not flagged on eighth word");
`endif

endmodule

// ===== design/hse_encoder.sv =====
module hse_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               word_valid,
  output logic               word_ready,
  input  hse_pkg::hse_word_t word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        codeword,
  output logic               section_end
);
  import hse_pkg::*;

  logic [CodeBits-1:0] cw_data, cw_full;
  logic [ParBits-1:0]  par;
  int                  nxt;

  assign word_ready = !out_valid || out_ready;

  // place data bits, first bit at position 3, skipping powers of two
  always_comb begin
    nxt     = DataBits;
    cw_data = '0;
    for (int pos = 1; pos <= CodeBits; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        nxt = nxt - 1;
        cw_data[CodeBits-pos] = word.data[nxt];
      end
    end
  end

  // even parity over positions whose index has bit k set
  always_comb begin
    par     = '0;
    cw_full = cw_data;
    for (int k = 0; k < ParBits; k++) begin
      for (int pos = 1; pos <= CodeBits; pos++) begin
        if (((pos >> k) & 1) != 0) begin
          par[k] = par[k] ^ cw_data[CodeBits-pos];
        end
      end
      cw_full[CodeBits-(1<<k)] = par[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word_ready) begin
      out_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && word_ready) begin
      codeword    <= cw_full;
      section_end <= word.last;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  import hse_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;
  localparam int PhaseItems  = 190;
  localparam int HoldCycles  = 80;
  localparam int PrintCap    = 30;

  // expected codeword and its section flag
  typedef struct {
    logic [CodeBits-1:0] codeword;
    logic                section_end;
  } coded_word_t;

  // Byte-to-codeword predictor with its own gearbox state, plus the queue of
  // codewords still owed by the block.
  class codeword_board;
    logic [32:0]       pend_bits;
    int                pend_cnt;
    logic [WordBits-1:0] word_idx;
    coded_word_t       owed[$];
    int                errors;

    function new();
      pend_bits = '0;
      pend_cnt  = 0;
      word_idx  = '0;
      errors    = 0;
    endfunction

    // data bits go to every non-power-of-two position, MSB first from position 3;
    // parity at 2^k covers positions with bit k set
    function automatic logic [CodeBits-1:0] hamming_encode(logic [DataBits-1:0] d);
      logic [CodeBits:1]   pos_bit;
      logic [CodeBits-1:0] cw;
      int                  idx;
      logic                par;
      pos_bit = '0;
      idx     = DataBits - 1;
      for (int pos = 1; pos <= CodeBits; pos++) begin
        if ((pos & (pos - 1)) != 0) begin
          pos_bit[pos] = d[idx];
          idx--;
        end
      end
      for (int k = 0; k < ParBits; k++) begin
        par = 1'b0;
        for (int pos = 1; pos <= CodeBits; pos++) begin
          if (((pos >> k) & 1) != 0) par ^= pos_bit[pos];
        end
        pos_bit[1 << k] = par;
      end
      for (int pos = 1; pos <= CodeBits; pos++) cw[CodeBits - pos] = pos_bit[pos];
      return cw;
    endfunction

    function void note_byte(logic [7:0] b);
      int                  rest;
      logic [DataBits-1:0] data;
      coded_word_t         w;
      pend_bits = (pend_bits << 8) | 33'(b);
      pend_cnt += 8;
      if (pend_cnt >= DataBits) begin
        rest          = pend_cnt - DataBits;
        data          = DataBits'(pend_bits >> rest);
        pend_bits     = pend_bits & ((33'd1 << rest) - 33'd1);
        pend_cnt      = rest;
        w.codeword    = hamming_encode(data);
        w.section_end = (word_idx == LastWord);
        word_idx      = word_idx + 1'b1;
        owed.push_back(w);
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (errors < PrintCap)
        $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_word(logic [31:0] tdata, logic tlast);
      coded_word_t w;
      if (owed.size() == 0) begin
        report("unexpected codeword", tdata, '0);
      end else begin
        w = owed.pop_front();
        if (tdata[CodeBits-1:0] !== w.codeword)
          report("codeword", 32'(tdata[CodeBits-1:0]), 32'(w.codeword));
        if (tlast !== w.section_end)
          report("section_end", 32'(tlast), 32'(w.section_end));
        if (tdata[31] !== 1'b0)
          report("pad bit", 32'(tdata[31]), '0);
      end
    endtask

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [30:0] codeword, [31] zero fill
  logic        m_axis_tlast;        // section_end

  codeword_board sb;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  hamming_31_26_byte_stream_encoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left     = hold_left - 1;
    end else begin
      m_axis_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // offer one byte, with random idle cycles ahead of it; returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 8'($urandom_range(255));
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    logic [7:0] directed[24];
    sb = new();
    // zero word, long runs of ones, single bits walking through a byte
    directed = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h0F,
                 8'hF0, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // full rate both sides
    foreach (directed[i]) send_byte(directed[i]);
    send_random(PhaseItems);

    idle_pct  = 63;
    send_random(PhaseItems);

    idle_pct  = 0;
    stall_pct = 63;
    send_random(PhaseItems);

    idle_pct  = 28;
    stall_pct = 28;
    send_random(PhaseItems);

    // receiver holds off while bytes keep coming, so the input backs up;
    // the item count leaves a trailing partial section; its bits short of a word never come out
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = HoldCycles;
    send_random(PhaseItems);

    s_axis_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
